/* rtl/slcan_pkg.sv */
// Shared types, character codes and helpers for the SLCAN line decoder.
// No dependencies; imported by slcan_line_decoder.
package slcan_pkg;

  // Largest data length code that a frame may carry
  localparam logic [3:0] MaxPayloadBytes = 4'd8;

  // Command and framing characters
  localparam logic [7:0] CharExtData = 8'h54;  // T
  localparam logic [7:0] CharExtRtr  = 8'h52;  // R
  localparam logic [7:0] CharStdData = 8'h74;  // t
  localparam logic [7:0] CharStdRtr  = 8'h72;  // r
  localparam logic [7:0] CharSpeed   = 8'h53;  // S
  localparam logic [7:0] CharOpen    = 8'h4f;  // O
  localparam logic [7:0] CharClose   = 8'h43;  // C
  localparam logic [7:0] CharListen  = 8'h4c;  // L
  localparam logic [7:0] CharCr      = 8'h0d;  // carriage return

  typedef enum logic [2:0] {
    KindBad    = 3'd0,
    KindOpen   = 3'd1,
    KindClose  = 3'd2,
    KindListen = 3'd3,
    KindSpeed  = 3'd4,
    KindFrame  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    kind_e       kind;
    logic [7:0]  command_char;
    logic [3:0]  speed_code;
    logic [28:0] frame_id;
    logic        extended;
    logic        remote;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } out_item_t;

  // Hex digit value; anything that is not a hex digit counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end
    return v;
  endfunction

endpackage

/* rtl/slcan_line_decoder.sv */
// Top level of the SLCAN ASCII command line decoder.
// Depends on slcan_pkg for item types, character codes and hex_value.
//
//  channel | direction | handshake                | item
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_item_t: character, line_end
//  out     | output    | out_valid_o / out_ready_i | out_item_t: decoded packet
//
// One character is taken per cycle; the line state updates at acceptance.
// The character flagged line_end yields its packet in the result register
// on the next cycle. The result register is the only stage, so input
// stalls only while a packet waits and out_ready_i is low.
// Reset clears the line state and drops any waiting packet.
module slcan_line_decoder
  import slcan_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [5:0]  char_pos_q, char_pos_d;
  logic [7:0]  first_char_q, first_char_d;
  logic        second_cr_q, second_cr_d;
  logic [28:0] id_acc_q, id_acc_d;
  logic [3:0]  dlc_q, dlc_d;
  logic [63:0] payload_q, payload_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;

  logic       in_fire;
  logic [7:0] ch;
  logic [7:0] fc;
  logic [3:0] nib;
  logic       ext_cmd, std_cmd, data_cmd;
  logic [3:0] id_digits;
  logic [5:0] dlc_pos;
  logic [5:0] data_off;
  logic [6:0] line_len, strip_len;
  logic [6:0] data_need;
  logic       frame_ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ch         = in_item_i.character;
  assign nib        = hex_value(ch);

  // Command character is the current one at the start of a line
  assign fc        = (char_pos_q == 6'd0) ? ch : first_char_q;
  assign ext_cmd   = (fc == CharExtData) || (fc == CharExtRtr);
  assign std_cmd   = (fc == CharStdData) || (fc == CharStdRtr);
  assign data_cmd  = (fc == CharExtData) || (fc == CharStdData);
  assign id_digits = ext_cmd ? 4'd8 : (std_cmd ? 4'd3 : 4'd1);
  assign dlc_pos   = ext_cmd ? 6'd9 : 6'd4;
  assign data_off  = char_pos_q - dlc_pos - 6'd1;

  // Accumulate the line fields for the current character
  always_comb begin
    first_char_d = first_char_q;
    second_cr_d  = second_cr_q;
    id_acc_d     = id_acc_q;
    dlc_d        = dlc_q;
    payload_d    = payload_q;
    if (char_pos_q == 6'd0) begin
      first_char_d = ch;
    end
    if (char_pos_q == 6'd1) begin
      second_cr_d = (ch == CharCr);
    end
    if (char_pos_q >= 6'd1 && char_pos_q <= {2'b00, id_digits}) begin
      id_acc_d = {id_acc_q[24:0], nib};
    end
    if ((ext_cmd || std_cmd) && char_pos_q == dlc_pos) begin
      dlc_d = nib;
    end
    // Place the data nibble into its byte lane, high nibble first
    if (data_cmd && char_pos_q > dlc_pos) begin
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < dlc_q) begin
          if (data_off == 6'(2 * i)) begin
            payload_d[8*i+4 +: 4] = payload_q[8*i+4 +: 4] | nib;
          end
          if (data_off == 6'(2 * i + 1)) begin
            payload_d[8*i +: 4] = payload_q[8*i +: 4] | nib;
          end
        end
      end
    end
  end

  // Advance the position, saturating on long lines
  always_comb begin
    if (in_item_i.line_end) begin
      char_pos_d = 6'd0;
    end else if (char_pos_q == 6'd63) begin
      char_pos_d = char_pos_q;
    end else begin
      char_pos_d = char_pos_q + 6'd1;
    end
  end

  // Length checks for frame commands
  assign line_len  = {1'b0, char_pos_q} + 7'd1;
  assign strip_len = (ch == CharCr) ? line_len - 7'd1 : line_len;
  assign data_need = {2'b00, dlc_d, 1'b0};

  always_comb begin
    frame_ok = 1'b0;
    if ((ext_cmd || std_cmd) && line_len >= 7'd5 && dlc_d <= MaxPayloadBytes) begin
      if (fc == CharExtData) begin
        frame_ok = strip_len >= 7'd10 && strip_len >= data_need + 7'd10;
      end else if (fc == CharExtRtr) begin
        frame_ok = strip_len >= 7'd10;
      end else if (fc == CharStdData) begin
        frame_ok = strip_len >= data_need + 7'd5;
      end else begin
        frame_ok = strip_len >= 7'd5;
      end
    end
  end

  // Decode the finished line into a packet
  always_comb begin
    out_item_d              = '0;
    out_item_d.kind         = KindBad;
    out_item_d.command_char = fc;
    if (fc == CharOpen) begin
      out_item_d.kind = KindOpen;
    end else if (fc == CharClose) begin
      out_item_d.kind = KindClose;
    end else if (fc == CharListen) begin
      out_item_d.kind = KindListen;
    end else if (fc == CharSpeed) begin
      if (line_len > 7'd1 && !second_cr_d) begin
        out_item_d.kind       = KindSpeed;
        out_item_d.speed_code = id_acc_d[3:0];
      end
    end else if (frame_ok) begin
      out_item_d.kind        = KindFrame;
      out_item_d.frame_id    = ext_cmd ? id_acc_d : {18'd0, id_acc_d[10:0]};
      out_item_d.extended    = ext_cmd;
      out_item_d.remote      = !data_cmd;
      out_item_d.data_length = dlc_d;
      out_item_d.payload     = data_cmd ? payload_d : 64'd0;
    end
    out_item_d.accepted = (out_item_d.kind != KindBad);
  end

  // Hold a packet until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && in_item_i.line_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q   <= '0;
      first_char_q <= '0;
      second_cr_q  <= 1'b0;
      id_acc_q     <= '0;
      dlc_q        <= '0;
      payload_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        char_pos_q <= char_pos_d;
        if (in_item_i.line_end) begin
          first_char_q <= '0;
          second_cr_q  <= 1'b0;
          id_acc_q     <= '0;
          dlc_q        <= '0;
          payload_q    <= '0;
        end else begin
          first_char_q <= first_char_d;
          second_cr_q  <= second_cr_d;
          id_acc_q     <= id_acc_d;
          dlc_q        <= dlc_d;
          payload_q    <= payload_d;
        end
      end
    end
  end

  // Result register, loaded on the line end
  always_ff @(posedge clk_i) begin
    if (in_fire && in_item_i.line_end) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_line_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_item_i.line_end |=> out_valid_o)
    else $error("line end did not produce a packet");

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_item_i.line_end |=> char_pos_q == 6'd0 && payload_q == 64'd0)
    else $error("line state not cleared after line end");

  a_accepted_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.accepted == (out_item_o.kind != KindBad))
    else $error("accepted flag disagrees with kind");

  a_frame_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KindFrame |->
      out_item_o.frame_id == 29'd0 && out_item_o.payload == 64'd0 &&
      out_item_o.data_length == 4'd0)
    else $error("frame fields set on a non-frame packet");

  a_frame_dlc_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KindFrame |->
      out_item_o.data_length <= MaxPayloadBytes)
    else $error("frame packet with oversized data length");
`endif

endmodule

/* dv/tb_slcan_line_decoder.sv */
`timescale 1ns / 1ps
// Testbench for slcan_line_decoder: feeds SLCAN command lines one character per
// item and checks every decoded packet against a cycle-free line predictor.
// Depends on slcan_pkg (item types, character codes) and the decoder RTL.
module tb_slcan_line_decoder;
  import slcan_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomChars = 310;
  localparam int unsigned RandomLines = 26;
  localparam int unsigned HoldStart   = 300;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned QuietLo     = 380;
  localparam int unsigned QuietHi     = 500;
  localparam int unsigned IdlePct     = 15;
  localparam int unsigned MaxReports  = 10;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pend_char_t;

  // Shapes of random command lines
  typedef enum {
    ShapeFrame, ShapeCommand, ShapeSpeed, ShapeCut,
    ShapeNoisy, ShapeJunk, ShapeTail, ShapeLong
  } line_shape_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  slcan_line_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  pend_char_t  char_queue[$];
  out_item_t   packet_queue[$];
  logic [7:0]  line_buf[$];

  // Line state of the predictor
  int unsigned line_pos = 0;
  logic [7:0]  line_cmd = '0;
  bit          speed_blank = 1'b0;
  logic [31:0] id_shift = '0;
  logic [3:0]  dlc_digit = '0;
  logic [63:0] data_bytes = '0;

  bit          in_taken = 1'b0;
  int unsigned in_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned mismatches = 0;
  int unsigned frames_ok = 0;
  int unsigned commands_ok = 0;
  int unsigned lines_bad = 0;

  logic [7:0] frame_cmds[4] = '{CharExtData, CharExtRtr, CharStdData, CharStdRtr};

  // Clock and reset
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if (low >= 8'h61 && low <= 8'h66) return 4'(low - 8'h57);
    return 4'd0;
  endfunction

  // Advance the line state by one character; emit a packet on the line end
  task automatic track_char(input in_item_t it);
    logic [7:0]  ch;
    logic [7:0]  fc;
    logic [3:0]  nib;
    int unsigned pos, id_digits, dlc_pos, off, byte_idx, line_len, stripped, dlc;
    bit          ext_cmd, std_cmd, ok;
    out_item_t   pkt;
    ch = it.character;
    pos = line_pos;
    fc = (pos == 0) ? ch : line_cmd;
    ext_cmd = (fc == CharExtData || fc == CharExtRtr);
    std_cmd = (fc == CharStdData || fc == CharStdRtr);
    id_digits = ext_cmd ? 8 : (std_cmd ? 3 : 1);
    dlc_pos = ext_cmd ? 9 : 4;
    nib = nibble_of(ch);

    if (pos == 0) line_cmd = ch;
    if (pos == 1) speed_blank = (ch == CharCr);
    if (pos >= 1 && pos <= id_digits) id_shift = {id_shift[27:0], nib};
    if ((ext_cmd || std_cmd) && pos == dlc_pos) dlc_digit = nib;
    // Store data nibbles, high nibble first, only within the DLC and 8 bytes
    if ((fc == CharExtData || fc == CharStdData) && pos > dlc_pos) begin
      off = pos - dlc_pos - 1;
      byte_idx = off / 2;
      if (byte_idx < dlc_digit && byte_idx < 8) begin
        data_bytes |= 64'(nib) << (byte_idx * 8 + ((off % 2 == 0) ? 4 : 0));
      end
    end

    if (!it.line_end) begin
      if (line_pos < 63) line_pos++;
      return;
    end

    line_len = pos + 1;
    stripped = (ch == CharCr) ? line_len - 1 : line_len;
    pkt = '0;
    pkt.kind = KindBad;
    pkt.command_char = fc;
    case (fc)
      CharOpen:   pkt.kind = KindOpen;
      CharClose:  pkt.kind = KindClose;
      CharListen: pkt.kind = KindListen;
      CharSpeed: begin
        if (line_len > 1 && !speed_blank) begin
          pkt.kind = KindSpeed;
          pkt.speed_code = id_shift[3:0];
        end
      end
      default: begin
        if ((ext_cmd || std_cmd) && line_len >= 5 && dlc_digit <= MaxPayloadBytes) begin
          dlc = dlc_digit;
          case (fc)
            CharExtData: ok = stripped >= 10 && stripped >= 2 * dlc + 10;
            CharExtRtr:  ok = stripped >= 10;
            CharStdData: ok = stripped >= 2 * dlc + 5;
            default:     ok = stripped >= 5;
          endcase
          if (ok) begin
            pkt.kind = KindFrame;
            pkt.frame_id = ext_cmd ? id_shift[28:0] : {18'd0, id_shift[10:0]};
            pkt.extended = ext_cmd;
            pkt.remote = (fc == CharExtRtr || fc == CharStdRtr);
            pkt.data_length = dlc_digit;
            pkt.payload = pkt.remote ? 64'd0 : data_bytes;
          end
        end
      end
    endcase
    pkt.accepted = (pkt.kind != KindBad);
    packet_queue.push_back(pkt);

    line_pos = 0;
    line_cmd = '0;
    speed_blank = 1'b0;
    id_shift = '0;
    dlc_digit = '0;
    data_bytes = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  function automatic bit quiet_now();
    return in_count >= QuietLo && in_count < QuietHi;
  endfunction

  function automatic bit idle_draw();
    return !quiet_now() && ($urandom_range(99) < IdlePct);
  endfunction

  // Check packets first, then let accepted characters update the predictor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (packet_queue.size() == 0) begin
          report_mismatch("packet with none expected", '0, out_item_o.payload);
        end else begin
          want = packet_queue.pop_front();
          check_field("accepted", want.accepted, out_item_o.accepted);
          check_field("kind", want.kind, out_item_o.kind);
          check_field("command_char", want.command_char, out_item_o.command_char);
          check_field("speed_code", want.speed_code, out_item_o.speed_code);
          check_field("frame_id", want.frame_id, out_item_o.frame_id);
          check_field("extended", want.extended, out_item_o.extended);
          check_field("remote", want.remote, out_item_o.remote);
          check_field("data_length", want.data_length, out_item_o.data_length);
          check_field("payload", want.payload, out_item_o.payload);
          if (want.kind == KindFrame) frames_ok++;
          else if (want.kind == KindBad) lines_bad++;
          else commands_ok++;
        end
      end
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        track_char(in_item_i);
        in_count <= in_count + 1;
      end
    end
  end

  // Hold off the receiver once for a long stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && in_count >= HoldStart) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Drive characters; hold the current item until it is accepted
  always @(negedge clk_i) begin
    pend_char_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (char_queue.size() != 0 && !(char_queue[0].drain && packet_queue.size() != 0)
          && !idle_draw()) begin
        nxt = char_queue.pop_front();
        in_valid_i <= 1'b1;
        in_item_i <= nxt.item;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive the receiver ready
  always @(negedge clk_i) begin
    if (!rst_ni || hold_left != 0) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !idle_draw();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb_slcan_line_decoder: errors");
    $finish;
  end

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((($urandom_range(1) != 0) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_hex(input int unsigned count);
    repeat (count) line_buf.push_back(hex_char($urandom_range(15)));
  endtask

  task automatic add_noise(input int unsigned count);
    repeat (count) line_buf.push_back(8'($urandom_range(255)));
  endtask

  // Move the line buffer into the character queue, flag the last character
  task automatic push_line(input bit drain);
    pend_char_t pc;
    foreach (line_buf[i]) begin
      pc.item.character = line_buf[i];
      pc.item.line_end = (i == line_buf.size() - 1);
      pc.drain = drain && (i == 0);
      char_queue.push_back(pc);
    end
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    push_line(1'b0);
  endtask

  // Frame command with random ID, DLC and data; the DLC is sometimes above 8
  task automatic make_frame();
    logic [7:0]  cmd;
    int unsigned dlc;
    cmd = frame_cmds[$urandom_range(3)];
    dlc = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
    line_buf.push_back(cmd);
    add_hex((cmd == CharExtData || cmd == CharExtRtr) ? 8 : 3);
    line_buf.push_back(hex_char(dlc));
    if (cmd == CharExtData || cmd == CharStdData) add_hex(2 * dlc);
    if ($urandom_range(1) != 0) line_buf.push_back(CharCr);
  endtask

  initial begin
    int unsigned n_chars, n_lines, pick, target, idx;
    line_shape_e shape;
    n_chars = 0;
    n_lines = 0;

    // Directed lines: plain commands, speed forms, frame limits and junk
    send_text("O");
    send_text("C\r");
    send_text("L");
    send_text("S6");
    send_text("S");
    send_text("S\r");
    send_text("Sf\r");
    send_text("t1230");
    send_text("t7FF80123456789abcdef\r");
    send_text("TFFFFFFFF8FFFFFFFFFFFFFFFF");
    send_text("T000000000\r");
    send_text("R123456784\r");
    send_text("r7FF");
    send_text("r7FF2");
    send_text("r12");
    send_text("t1232AB");
    send_text("tABC1\r");
    send_text("t1239112233445566778899");
    send_text("T12345678F");
    send_text("T12345678");
    send_text("t12g1zz");
    send_text("Xyz");
    send_text("\r");
    line_buf.push_back(8'hFF);
    push_line(1'b0);
    line_buf.push_back(8'h00);
    push_line(1'b0);
    // Line long enough to saturate the position counter
    add_text("t1238");
    add_hex(16);
    add_noise(50);
    push_line(1'b0);

    // Random lines of several shapes, most built from frame commands with random content
    while (n_chars < RandomChars || n_lines < RandomLines) begin
      pick = $urandom_range(99);
      if (pick < 35) shape = ShapeFrame;
      else if (pick < 47) shape = ShapeCommand;
      else if (pick < 57) shape = ShapeSpeed;
      else if (pick < 69) shape = ShapeCut;
      else if (pick < 79) shape = ShapeNoisy;
      else if (pick < 89) shape = ShapeJunk;
      else if (pick < 97) shape = ShapeTail;
      else shape = ShapeLong;
      case (shape)
        ShapeFrame: make_frame();
        ShapeCommand: begin
          pick = $urandom_range(2);
          line_buf.push_back(pick == 0 ? CharOpen : (pick == 1 ? CharClose : CharListen));
          pick = $urandom_range(3);
          if (pick == 1) line_buf.push_back(CharCr);
          else if (pick == 2) add_noise($urandom_range(1, 3));
        end
        ShapeSpeed: begin
          line_buf.push_back(CharSpeed);
          pick = $urandom_range(9);
          if (pick == 1) begin
            line_buf.push_back(CharCr);
          end else if (pick == 2) begin
            add_noise(1);
          end else if (pick > 2) begin
            line_buf.push_back(hex_char($urandom_range(15)));
            if ($urandom_range(1) != 0) line_buf.push_back(CharCr);
          end
        end
        ShapeCut: begin
          make_frame();
          target = $urandom_range(1, line_buf.size() > 1 ? line_buf.size() - 1 : 1);
          while (line_buf.size() > target) void'(line_buf.pop_back());
        end
        ShapeNoisy: begin
          make_frame();
          repeat ($urandom_range(1, 3)) begin
            idx = $urandom_range(1, line_buf.size() - 1);
            line_buf[idx] = 8'($urandom_range(255));
          end
        end
        ShapeJunk: add_noise($urandom_range(1, 8));
        ShapeTail: begin
          make_frame();
          if ($urandom_range(1) != 0) add_hex($urandom_range(1, 4));
          else add_noise($urandom_range(1, 4));
        end
        default: begin
          make_frame();
          target = $urandom_range(72, 64);
          while (line_buf.size() < target) add_noise(1);
        end
      endcase
      n_chars += line_buf.size();
      // Pause the sender until the block has drained, twice
      push_line(n_lines == 0 || n_lines == 25);
      n_lines++;
    end

    // Wait for all characters to go in and all packets to come out
    while (char_queue.size() != 0 || in_valid_i) @(negedge clk_i);
    while (packet_queue.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("run covered %0d lines from %0d characters: %0d frames, %0d commands, %0d rejected",
             frames_ok + commands_ok + lines_bad, in_count, frames_ok, commands_ok, lines_bad);
    $display("receiver hold-off and sender drain pauses exercised, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_slcan_line_decoder: clean");
    end else begin
      $display("tb_slcan_line_decoder: errors");
    end
    $finish;
  end

endmodule

/* slcan_line_decoder.f */
rtl/slcan_pkg.sv
rtl/slcan_line_decoder.sv
dv/tb_slcan_line_decoder.sv
